/* rtl/csp_pkg.sv */
// shared types and constants for the color string parser
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package csp_pkg;

  // string form decided by the first characters
  typedef enum logic [1:0] {
    FORM_NONE = 2'd0,
    FORM_HEX  = 2'd1,
    FORM_RGB  = 2'd2,
    FORM_RGBA = 2'd3
  } form_t;

  // result error codes
  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_FORM     = 3'd1,
    ERR_HEX_LEN  = 3'd2,
    ERR_BAD_CHAR = 3'd3,
    ERR_PARTS    = 3'd4,
    ERR_RANGE    = 3'd5,
    ERR_NO_CLOSE = 3'd6
  } err_t;

  // register map, word index taken from paddr[2]
  localparam logic REG_USE_FALLBACK   = 1'b0;
  localparam logic REG_FALLBACK_COLOR = 1'b1;

  localparam int unsigned PADDR_W = 3;

  localparam logic [3:0] POS_MAX   = 4'hf;
  localparam logic [8:0] PART_SAT  = 9'd256;
  localparam logic [8:0] PART_MAX  = 9'd255;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_R     = 8'h72;

  // per-string parse state
  typedef struct packed {
    form_t       form;
    logic [3:0]  pos;
    logic [31:0] hex;
    logic [1:0]  part_idx;
    logic [8:0]  red;
    logic [8:0]  green;
    logic [8:0]  blue;
    logic [8:0]  alpha;
    err_t        err;
    logic        close_seen;
  } parse_state_t;

  // configuration seen by the datapath
  typedef struct packed {
    logic        use_fallback;
    logic [31:0] fallback_color;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/color_string_parser_unit.sv */
// top level of the color string parser: input stage, parse state, result register
// depends on csp_pkg, csp_apb_regs, csp_char_logic
`timescale 1ns / 1ps
`default_nettype none

// channel   | signals                          | beat
// ----------+----------------------------------+------------------------------------
// input     | in_valid, in_ready, ch, last     | one character, last marks string end
// result    | out_valid, out_ready, color,     | one result per string, on its last
//           | error, error_code                | character
// config    | psel, penable, pwrite, paddr,    | apb write/read, word 0 use_fallback,
//           | pwdata, prdata, pready           | word 1 fallback_color
//
// one character per cycle sustained unless a stalled result holds a last character;
// a result is registered through the input stage register, then the result register
// the character step is a single pass of compare/shift/multiply-by-ten logic
// rst is synchronous: clears config, parse state and both valid flags
// a stalled result only holds back a last character; plain characters keep
// flowing through the parse state while the result waits

module color_string_parser_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // character channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [7:0]                  ch,
  input  wire logic                        last,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [31:0]                      color,
  output logic                             error,
  output logic [2:0]                       error_code,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [csp_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);
  import csp_pkg::*;

  cfg_t         cfg;
  parse_state_t state;
  parse_state_t state_next;

  // input stage
  logic       stg_valid;
  logic [7:0] stg_ch;
  logic       stg_last;
  logic       stg_adv;

  // result of the staged character
  logic [31:0] res_color;
  logic        res_error;
  err_t        res_code;

  csp_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  csp_char_logic u_logic (
    .st         (state),
    .cfg        (cfg),
    .ch         (stg_ch),
    .last       (stg_last),
    .st_next    (state_next),
    .color      (res_color),
    .error      (res_error),
    .error_code (res_code)
  );

  // a plain character always moves on; a last one needs a free result slot
  assign stg_adv  = stg_valid && (!stg_last || !out_valid || out_ready);
  assign in_ready = !stg_valid || stg_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (in_ready) begin
      stg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_ch   <= ch;
      stg_last <= last;
    end
  end

  // parse state advances once per staged character
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (stg_adv) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stg_adv && stg_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_adv && stg_last) begin
      color      <= res_color;
      error      <= res_error;
      error_code <= res_code;
    end
  end

  // string end leaves a clean parse state
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    stg_adv && stg_last |=> state == parse_state_t'('0))
    else $error("parse state not cleared after last character");

  // error flag and code agree on every result
  a_error_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (error == (error_code != ERR_NONE)))
    else $error("error flag disagrees with error code");

  // character count steps by one per plain character until it saturates
  a_pos_counts: assert property (@(posedge clk) disable iff (rst)
    stg_adv && !stg_last && (state.pos != POS_MAX)
    |=> state.pos == $past(state.pos) + 4'd1)
    else $error("character position did not advance");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !(stg_adv && stg_last))
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

/* rtl/csp_apb_regs.sv */
// apb register file: use_fallback and fallback_color
// depends on csp_pkg
`timescale 1ns / 1ps
`default_nettype none

module csp_apb_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [csp_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  output csp_pkg::cfg_t                    cfg
);
  import csp_pkg::*;

  logic wr_en;

  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_USE_FALLBACK:   cfg.use_fallback   <= pwdata[0];
        REG_FALLBACK_COLOR: cfg.fallback_color <= pwdata;
        default:            cfg <= cfg;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_USE_FALLBACK:   prdata = {31'd0, cfg.use_fallback};
      REG_FALLBACK_COLOR: prdata = cfg.fallback_color;
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/csp_char_logic.sv */
// per-character next-state and end-of-string result logic
// depends on csp_pkg
`timescale 1ns / 1ps
`default_nettype none

module csp_char_logic (
  input  wire csp_pkg::parse_state_t st,
  input  wire csp_pkg::cfg_t         cfg,
  input  wire logic [7:0]            ch,
  input  wire logic                  last,
  output csp_pkg::parse_state_t      st_next,
  output logic [31:0]                color,
  output logic                       error,
  output csp_pkg::err_t              error_code
);
  import csp_pkg::*;

  // decimal part update, saturating at 256
  function automatic logic [8:0] acc_part(input logic [8:0] v, input logic [3:0] d);
    logic [12:0] n;
    n = ({4'd0, v} << 3) + ({4'd0, v} << 1) + {9'd0, d};
    return (n > {4'd0, PART_SAT}) ? PART_SAT : n[8:0];
  endfunction

  parse_state_t s;
  logic         is_dec;
  logic         hex_ok;
  logic [3:0]   hex_val;
  logic [3:0]   dec_val;
  logic [1:0]   last_idx;
  err_t         err;
  logic [7:0]   a_byte;

  assign is_dec  = (ch >= CH_0) && (ch <= CH_9);
  assign dec_val = 4'(ch - CH_0);

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = dec_val;
    if (is_dec) begin
      hex_val = dec_val;
    end else if ((ch >= CH_A) && (ch <= CH_F)) begin
      hex_val = 4'(ch - CH_A + 8'd10);
    end else if ((ch >= CH_UA) && (ch <= CH_UF)) begin
      hex_val = 4'(ch - CH_UA + 8'd10);
    end else begin
      hex_ok  = 1'b0;
    end
  end

  assign last_idx = (st.form == FORM_RGBA) ? 2'd3 : 2'd2;

  // character step
  always_comb begin
    s = st;
    if (st.err == ERR_NONE) begin
      if (st.pos == 4'd0) begin
        if (ch == CH_HASH) begin
          s.form = FORM_HEX;
        end else if ((ch == CH_R) && !cfg.use_fallback) begin
          s.form = FORM_RGB;
        end else begin
          s.err = ERR_FORM;
        end
      end else if (st.form == FORM_HEX) begin
        if (!hex_ok) s.err = ERR_BAD_CHAR;
        else         s.hex = {st.hex[27:0], hex_val};
      end else if ((st.form == FORM_RGB) && (st.pos <= 4'd3)) begin
        if (st.pos == 4'd1) begin
          if (ch != CH_G) s.err = ERR_FORM;
        end else if (st.pos == 4'd2) begin
          if (ch != CH_B) s.err = ERR_FORM;
        end else if (ch == CH_A) begin
          s.form = FORM_RGBA;
        end else if (ch != CH_LPAR) begin
          s.err = ERR_FORM;
        end
      end else if ((st.form == FORM_RGBA) && (st.pos == 4'd4)) begin
        if (ch != CH_LPAR) s.err = ERR_FORM;
      end else begin
        // part list body
        if (st.close_seen) begin
          s.err = ERR_BAD_CHAR;
        end else if (ch == CH_RPAR) begin
          s.close_seen = 1'b1;
        end else if (ch == CH_COMMA) begin
          if (st.part_idx >= last_idx) s.err = ERR_PARTS;
          else                         s.part_idx = st.part_idx + 2'd1;
        end else if (is_dec) begin
          unique case (st.part_idx)
            2'd0: s.red   = acc_part(st.red, dec_val);
            2'd1: s.green = acc_part(st.green, dec_val);
            2'd2: s.blue  = acc_part(st.blue, dec_val);
            default: s.alpha = acc_part(st.alpha, dec_val);
          endcase
        end else begin
          s.err = ERR_BAD_CHAR;
        end
      end
    end
    if (st.pos != POS_MAX) s.pos = st.pos + 4'd1;
  end

  // end-of-string checks, pos is the count before this character
  always_comb begin
    err    = s.err;
    color  = '0;
    a_byte = (s.form == FORM_RGB) ? ALPHA_OPAQUE : s.alpha[7:0];
    if (s.err == ERR_NONE) begin
      if (s.form == FORM_HEX) begin
        if (st.pos == 4'd6)      color = {ALPHA_OPAQUE, s.hex[23:0]};
        else if (st.pos == 4'd8) color = s.hex;
        else                     err = ERR_HEX_LEN;
      end else if (cfg.use_fallback) begin
        err = ERR_FORM;
      end else if (((s.form == FORM_RGB) && (st.pos < 4'd3)) ||
                   ((s.form == FORM_RGBA) && (st.pos < 4'd4)) ||
                   (s.form == FORM_NONE)) begin
        err = ERR_FORM;
      end else if (!s.close_seen) begin
        err = ERR_NO_CLOSE;
      end else if ((s.red > PART_MAX) || (s.green > PART_MAX) ||
                   (s.blue > PART_MAX) || (s.alpha > PART_MAX)) begin
        err = ERR_RANGE;
      end else begin
        color = {a_byte, s.red[7:0], s.green[7:0], s.blue[7:0]};
      end
    end
    if (err != ERR_NONE) color = cfg.use_fallback ? cfg.fallback_color : 32'd0;
    error      = (err != ERR_NONE);
    error_code = err;
    st_next    = last ? parse_state_t'('0) : s;
  end

endmodule

`default_nettype wire

/* bench/color_string_parser_unit_tb.sv */
// testbench for color_string_parser_unit: directed color strings, then random phases
// each result is checked against an in-bench parser model or a hand-typed row; depends on csp_pkg and the unit
`timescale 1ns / 1ps

module color_string_parser_unit_tb;
  import csp_pkg::*;

  localparam int          RANDOM_CHARS = 1200;
  localparam int          STALL_LIMIT  = 2000;
  localparam logic [31:0] ALT_COLOR    = 32'h80a0c0e0;

  typedef logic [7:0] text_t[$];

  // one result beat as the parser should produce it
  typedef struct {
    logic [31:0] color;
    logic        error;
    err_t        code;
  } parse_result_t;

  // directed row: the string, the mode it runs in, and a hand-typed result where obvious
  typedef struct {
    string       text;
    logic        fallback;
    logic        typed;
    logic [31:0] color;
    err_t        code;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          ch = '0;
  logic                last = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [31:0]         color;
  logic                error;
  logic [2:0]          error_code;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  color_string_parser_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .ch         (ch),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .color      (color),
    .error      (error),
    .error_code (error_code),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // parser model: configuration copy and per-string state
  // ---------------------------------------------------------------------------
  logic        cfg_fallback = 1'b0;
  logic [31:0] cfg_color    = '0;

  form_t       st_form  = FORM_NONE;
  logic [3:0]  st_pos   = '0;
  logic [31:0] st_hex   = '0;
  logic [2:0]  st_part  = '0;
  logic [8:0]  st_red   = '0;
  logic [8:0]  st_green = '0;
  logic [8:0]  st_blue  = '0;
  logic [8:0]  st_alpha = '0;
  err_t        st_err   = ERR_NONE;
  logic        st_close = 1'b0;

  parse_result_t parsed_q[$];

  // bookkeeping for the closing summary and the verdict
  int  fail_count   = 0;
  int  chars_sent   = 0;
  int  strings_sent = 0;
  int  fb_strings   = 0;
  int  results_seen = 0;
  int  rejects_seen = 0;
  int  idle_cycles  = 0;
  // phases with no idling on either side
  logic steady = 1'b0;

  function automatic int hex_digit_value(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_A && c <= CH_F) return int'(c - CH_A) + 10;
    if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    return -1;
  endfunction

  // decimal digit into a part, saturating at 256
  function automatic logic [8:0] dec_shift(input logic [8:0] v, input logic [7:0] c);
    int n;
    n = int'(v) * 10 + int'(c - CH_0);
    return (n > int'(PART_SAT)) ? PART_SAT : n[8:0];
  endfunction

  function automatic void clear_parse();
    st_form  = FORM_NONE;
    st_pos   = '0;
    st_hex   = '0;
    st_part  = '0;
    st_red   = '0;
    st_green = '0;
    st_blue  = '0;
    st_alpha = '0;
    st_err   = ERR_NONE;
    st_close = 1'b0;
  endfunction

  // characters inside the parentheses of rgb / rgba
  function automatic void parse_body(input logic [7:0] c);
    int nparts;
    nparts = (st_form == FORM_RGBA) ? 4 : 3;
    if (st_close) begin
      st_err = ERR_BAD_CHAR;
    end else if (c == CH_RPAR) begin
      st_close = 1'b1;
    end else if (c == CH_COMMA) begin
      if (int'(st_part) + 1 >= nparts) st_err = ERR_PARTS;
      else st_part = st_part + 3'd1;
    end else if (c >= CH_0 && c <= CH_9) begin
      case (st_part)
        3'd0: st_red = dec_shift(st_red, c);
        3'd1: st_green = dec_shift(st_green, c);
        3'd2: st_blue = dec_shift(st_blue, c);
        default: st_alpha = dec_shift(st_alpha, c);
      endcase
    end else begin
      st_err = ERR_BAD_CHAR;
    end
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    int h;
    // after the first error everything up to the end of the string is ignored
    if (st_err != ERR_NONE) return;
    if (st_pos == 4'd0) begin
      if (c == CH_HASH) st_form = FORM_HEX;
      else if (c == CH_R && !cfg_fallback) st_form = FORM_RGB;
      else st_err = ERR_FORM;
    end else if (st_form == FORM_HEX) begin
      h = hex_digit_value(c);
      if (h < 0) st_err = ERR_BAD_CHAR;
      else st_hex = {st_hex[27:0], h[3:0]};
    end else if (st_form == FORM_RGB && st_pos <= 4'd3) begin
      if (st_pos == 4'd1) begin
        if (c != CH_G) st_err = ERR_FORM;
      end else if (st_pos == 4'd2) begin
        if (c != CH_B) st_err = ERR_FORM;
      end else if (c == CH_A) begin
        st_form = FORM_RGBA;
      end else if (c != CH_LPAR) begin
        st_err = ERR_FORM;
      end
    end else if (st_form == FORM_RGBA && st_pos == 4'd4) begin
      if (c != CH_LPAR) st_err = ERR_FORM;
    end else begin
      parse_body(c);
    end
  endfunction

  // end-of-string checks; pos is the position of the last character
  function automatic parse_result_t close_string(input logic [3:0] pos);
    parse_result_t r;
    err_t          e;
    logic [7:0]    a;
    int            len;
    e = st_err;
    r.color = '0;
    len = int'(pos) + 1;
    if (e == ERR_NONE) begin
      if (st_form == FORM_HEX) begin
        if (len == 7) r.color = {ALPHA_OPAQUE, st_hex[23:0]};
        else if (len == 9) r.color = st_hex;
        else e = ERR_HEX_LEN;
      end else if (cfg_fallback) begin
        e = ERR_FORM;
      end else if ((st_form == FORM_RGB && pos < 4'd3) ||
                   (st_form == FORM_RGBA && pos < 4'd4) || st_form == FORM_NONE) begin
        // prefix cut short
        e = ERR_FORM;
      end else if (!st_close) begin
        e = ERR_NO_CLOSE;
      end else if (st_red > PART_MAX || st_green > PART_MAX ||
                   st_blue > PART_MAX || st_alpha > PART_MAX) begin
        e = ERR_RANGE;
      end else begin
        a = (st_form == FORM_RGB) ? ALPHA_OPAQUE : st_alpha[7:0];
        r.color = {a, st_red[7:0], st_green[7:0], st_blue[7:0]};
      end
    end
    if (e != ERR_NONE) r.color = cfg_fallback ? cfg_color : '0;
    r.error = (e != ERR_NONE);
    r.code  = e;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // character channel driver; the model is stepped at the accepting edge
  // ---------------------------------------------------------------------------
  task automatic push_char(input logic [7:0] c, input logic l, input logic typed = 1'b0,
                           input logic [31:0] typed_color = '0,
                           input err_t typed_code = ERR_NONE);
    int            gap;
    logic [3:0]    pos;
    parse_result_t r;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    ch       <= c;
    last     <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // beat taken at this edge
    chars_sent++;
    pos = st_pos;
    parse_char(c);
    if (st_pos != POS_MAX) st_pos = st_pos + 4'd1;
    if (l) begin
      r = close_string(pos);
      // hand-typed rows replace the model's answer
      if (typed) begin
        r.color = typed_color;
        r.error = (typed_code != ERR_NONE);
        r.code  = typed_code;
      end
      parsed_q.push_back(r);
      strings_sent++;
      if (cfg_fallback) fb_strings++;
      clear_parse();
    end
  endtask

  // drop valid, wait for every result, then give the two-stage pipe time to drain
  task automatic settle();
    in_valid <= 1'b0;
    while (parsed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  task automatic apb_write(input logic idx, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input logic idx, input logic [31:0] want);
    logic [31:0] got;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) begin
      $display("%0t: register %0d read expected %h got %h", $time, idx, want, got);
      fail_count++;
    end
  endtask

  task automatic set_config(input logic fb, input logic [31:0] col);
    apb_write(REG_USE_FALLBACK, {31'b0, fb});
    apb_write(REG_FALLBACK_COLOR, col);
    cfg_fallback = fb;
    cfg_color    = col;
    apb_read(REG_USE_FALLBACK, {31'b0, fb});
    apb_read(REG_FALLBACK_COLOR, col);
  endtask

  // ---------------------------------------------------------------------------
  // random string builder
  // ---------------------------------------------------------------------------
  function automatic void push_text(ref text_t t, input string s);
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return CH_0 + 8'(v);
    return ($urandom_range(0, 1) ? CH_A : CH_UA) + 8'(v - 10);
  endfunction

  function automatic void make_string(ref text_t t);
    int   kind;
    int   n;
    int   nparts;
    logic with_alpha;
    t = {};
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2: begin
        // well-formed hex, 6 or 8 digits
        t.push_back(CH_HASH);
        n = $urandom_range(0, 1) ? 6 : 8;
        repeat (n) t.push_back(rand_hex_char());
      end
      3: begin
        // hex with 0 to 12 digits, sometimes a stray character
        t.push_back(CH_HASH);
        n = $urandom_range(0, 12);
        repeat (n) t.push_back(rand_hex_char());
        if (t.size() > 1 && $urandom_range(0, 1))
          t[$urandom_range(1, t.size() - 1)] = 8'($urandom_range(0, 255));
      end
      4, 5, 6, 7: begin
        // decimal list, mostly well formed
        with_alpha = $urandom_range(0, 1);
        push_text(t, with_alpha ? "rgba(" : "rgb(");
        nparts = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 5) : (with_alpha ? 4 : 3);
        for (int k = 0; k < nparts; k++) begin
          if (k > 0) t.push_back(CH_COMMA);
          case ($urandom_range(0, 9))
            0: ; // empty part
            1: push_text(t, $sformatf("%0d", $urandom_range(256, 99999)));
            2: push_text(t, $sformatf("00%0d", $urandom_range(0, 255)));
            3: push_text(t, $urandom_range(0, 1) ? "255" : "0");
            default: push_text(t, $sformatf("%0d", $urandom_range(0, 255)));
          endcase
        end
        if ($urandom_range(0, 9) != 0) t.push_back(CH_RPAR);
        // broken variant: overwrite, cut or extend
        if (kind == 7) begin
          case ($urandom_range(0, 2))
            0: t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
            1: begin
              n = $urandom_range(1, t.size());
              while (t.size() > n) void'(t.pop_back());
            end
            default: t.push_back(8'($urandom_range(0, 255)));
          endcase
        end
      end
      8: begin
        // raw noise over the whole byte range
        n = $urandom_range(1, 20);
        repeat (n) t.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        // prefix that stops early
        push_text(t, "rgba(");
        n = $urandom_range(1, 5);
        while (t.size() > n) void'(t.pop_back());
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // directed table: extremes, every error code, fallback mode
  // ---------------------------------------------------------------------------
  dir_row_t dir_rows [25] = '{
    '{"#000000",             1'b0, 1'b1, 32'hff000000, ERR_NONE},
    '{"#FFFFFFFF",           1'b0, 1'b1, 32'hffffffff, ERR_NONE},
    '{"#a1B2c3",             1'b0, 1'b0, 32'h0,        ERR_NONE},
    '{"#12345678",           1'b0, 1'b1, 32'h12345678, ERR_NONE},
    '{"#12345",              1'b0, 1'b1, 32'h0,        ERR_HEX_LEN},
    '{"#1234567890",         1'b0, 1'b1, 32'h0,        ERR_HEX_LEN},
    '{"#12g456",             1'b0, 1'b1, 32'h0,        ERR_BAD_CHAR},
    '{"x",                   1'b0, 1'b1, 32'h0,        ERR_FORM},
    '{"\377",                1'b0, 1'b1, 32'h0,        ERR_FORM},
    '{"rgb(255,255,255)",    1'b0, 1'b1, 32'hffffffff, ERR_NONE},
    '{"rgba(0,0,0,0)",       1'b0, 1'b1, 32'h0,        ERR_NONE},
    '{"rgba(18,52,86,120)",  1'b0, 1'b0, 32'h0,        ERR_NONE},
    '{"rgb(1,2)",            1'b0, 1'b0, 32'h0,        ERR_NONE},
    '{"rgb",                 1'b0, 1'b1, 32'h0,        ERR_FORM},
    '{"rgb(",                1'b0, 1'b1, 32'h0,        ERR_NO_CLOSE},
    '{"rgb(1,2,3,4)",        1'b0, 1'b1, 32'h0,        ERR_PARTS},
    '{"rgb(256,0,0)",        1'b0, 1'b1, 32'h0,        ERR_RANGE},
    '{"rgb(99999,0,0)",      1'b0, 1'b0, 32'h0,        ERR_NONE},
    '{"rgb(1,2,3))",         1'b0, 1'b1, 32'h0,        ERR_BAD_CHAR},
    '{"rgb(1,2,3",           1'b0, 1'b1, 32'h0,        ERR_NO_CLOSE},
    '{"rgb(0000000001,2,3)", 1'b0, 1'b0, 32'h0,        ERR_NONE},
    '{"#123456",             1'b1, 1'b1, 32'hff123456, ERR_NONE},
    '{"rgb(1,2,3)",          1'b1, 1'b1, ALT_COLOR,    ERR_FORM},
    '{"#12",                 1'b1, 1'b1, ALT_COLOR,    ERR_HEX_LEN},
    '{"rga(",                1'b0, 1'b1, 32'h0,        ERR_FORM}
  };

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    text_t       txt;
    int          random_chars;
    int          nstr;
    logic        fb;
    logic [31:0] col;
    random_chars = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed rows start from the reset configuration
    foreach (dir_rows[i]) begin
      if (dir_rows[i].fallback != cfg_fallback) begin
        settle();
        set_config(dir_rows[i].fallback, ALT_COLOR);
      end
      for (int j = 0; j < dir_rows[i].text.len(); j++)
        push_char(dir_rows[i].text[j], j == dir_rows[i].text.len() - 1, dir_rows[i].typed,
                  dir_rows[i].color, dir_rows[i].code);
    end

    // random phases, each with its own register setting and idling style
    while (random_chars < RANDOM_CHARS) begin
      settle();
      fb = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 3))
        0: col = '0;
        1: col = '1;
        default: col = $urandom;
      endcase
      set_config(fb, col);
      steady = ($urandom_range(0, 3) == 0);
      nstr = $urandom_range(8, 20);
      repeat (nstr) begin
        make_string(txt);
        foreach (txt[j]) push_char(txt[j], j == txt.size() - 1);
        random_chars += txt.size();
      end
    end

    settle();
    repeat (8) @(posedge clk);
    $display("covered %0d characters in %0d strings (%0d in fallback mode)",
             chars_sent, strings_sent, fb_strings);
    $display("checked %0d results, %0d of them rejected strings", results_seen, rejects_seen);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // result side backpressure, a fresh stall drawn for each result beat
  initial begin : result_sink
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  // result checker: every beat against the oldest expected result
  always @(posedge clk) begin
    parse_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (error) rejects_seen++;
      if (parsed_q.size() == 0) begin
        $display("%0t: result with none expected, color %h error %b code %0d",
                 $time, color, error, error_code);
        fail_count++;
      end else begin
        want = parsed_q.pop_front();
        if (color !== want.color) begin
          $display("%0t: color expected %h got %h", $time, want.color, color);
          fail_count++;
        end
        if (error !== want.error) begin
          $display("%0t: error expected %b got %b", $time, want.error, error);
          fail_count++;
        end
        if (error_code !== want.code) begin
          $display("%0t: error_code expected %0d got %0d", $time, want.code, error_code);
          fail_count++;
        end
      end
    end
  end

  // watchdog: any beat on any channel counts as progress
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d results outstanding",
               $time, idle_cycles, parsed_q.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
